// ----- design/color_matrix_pixel_filter_macros.svh -----
// ----------------------------------------------------------------------------
// color_matrix_pixel_filter_macros
// assertion macros for the color matrix pixel filter, clocked on clock and
// disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef COLOR_MATRIX_PIXEL_FILTER_MACROS_SVH
`define COLOR_MATRIX_PIXEL_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CMPF_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CMPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CMPF_ASSERT(label, ante, cons, msg)

`define CMPF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- design/cmpf_pkg.sv -----
// ----------------------------------------------------------------------------
// cmpf_pkg
// shared types and constants of the color matrix pixel filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmpf_pkg;

   localparam int PIX_WIDTH   = 32;
   localparam int CHAN_BITS   = 8;
   localparam int CHAN_COUNT  = 4;
   localparam int COLOR_COUNT = 3;
   localparam int CHAN_ALPHA  = 3;
   localparam int COEF_WIDTH  = 16;
   localparam int CSR_WIDTH   = 64;

   localparam logic [CHAN_BITS-1:0] PIX_MAX = 8'hFF;

   // register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_ROW_ZERO  = 3'd0,
      CSR_ROW_ONE   = 3'd1,
      CSR_ROW_TWO   = 3'd2,
      CSR_ROW_THREE = 3'd3,
      CSR_OFFSET    = 3'd4
   } csr_index_type;

   // identity matrix and zero offset after reset
   localparam logic [CSR_WIDTH-1:0] ROW_ZERO_RESET  = 64'h0000_0000_0000_1000;
   localparam logic [CSR_WIDTH-1:0] ROW_ONE_RESET   = 64'h0000_0000_1000_0000;
   localparam logic [CSR_WIDTH-1:0] ROW_TWO_RESET   = 64'h0000_1000_0000_0000;
   localparam logic [CSR_WIDTH-1:0] ROW_THREE_RESET = 64'h1000_0000_0000_0000;
   localparam logic [CSR_WIDTH-1:0] OFFSET_RESET    = 64'h0000_0000_0000_0000;

endpackage

// ----- design/cmpf_unpremul.sv -----
// ----------------------------------------------------------------------------
// cmpf_unpremul
// two-stage unpremultiply: colour over alpha by reciprocal table and multiply,
// alpha over 255 by table, all with coef_frac_bits fraction bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmpf_unpremul
   import cmpf_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [PIX_WIDTH-1:0]                          in_pixel,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [CHAN_COUNT-1:0][CHAN_BITS+COEF_FRAC_BITS-1:0] out_vec
);

   localparam int VW        = CHAN_BITS + COEF_FRAC_BITS;
   localparam int RCP_SHIFT = 16 + COEF_FRAC_BITS;
   localparam int RW        = RCP_SHIFT + 1;
   localparam int QW        = RW + CHAN_BITS;
   localparam int TAB_DEPTH = 1 << CHAN_BITS;

   // ceil(2^RCP_SHIFT / a) gives an exact floor quotient for every
   // numerator below 2^(8+frac); entry zero is zero so a clear pixel maps to 0
   logic [RW-1:0] rcp_table   [TAB_DEPTH];
   logic [VW-1:0] alpha_table [TAB_DEPTH];

   for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
      localparam logic [63:0] RCP_VAL = (g == 0) ? 64'd0 :
         (((64'd1 << RCP_SHIFT) + 64'(g) - 64'd1) / 64'((g == 0) ? 1 : g));
      localparam logic [63:0] ALPHA_VAL = (64'(g) << COEF_FRAC_BITS) / 64'd255;
      assign rcp_table[g]   = RCP_VAL[RW-1:0];
      assign alpha_table[g] = ALPHA_VAL[VW-1:0];
   end

   logic                 s1_valid_ff;
   logic                 s1_ready;
   logic [CHAN_BITS-1:0] s1_chan_ff [COLOR_COUNT];
   logic [RW-1:0]        s1_rcp_ff;
   logic [VW-1:0]        s1_alpha_ff;

   logic                 s2_valid_ff;
   logic                 s2_ready;
   logic [QW-1:0]        quot_prod [COLOR_COUNT];
   logic [CHAN_COUNT-1:0][VW-1:0] vec_in;
   logic [CHAN_COUNT-1:0][VW-1:0] vec_ff;

   logic [CHAN_BITS-1:0] alpha_byte;

   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_vec   = vec_ff;

   assign alpha_byte = in_pixel[CHAN_ALPHA*CHAN_BITS +: CHAN_BITS];

   // stage one: table lookups
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         for (int i = 0; i < COLOR_COUNT; i++) begin
            s1_chan_ff[i] <= in_pixel[CHAN_BITS*(COLOR_COUNT-1-i) +: CHAN_BITS];
         end
         s1_rcp_ff   <= rcp_table[alpha_byte];
         s1_alpha_ff <= alpha_table[alpha_byte];
      end
   end

   // stage two: colour times reciprocal
   always_comb begin
      for (int i = 0; i < COLOR_COUNT; i++) begin
         quot_prod[i] = QW'(s1_chan_ff[i]) * QW'(s1_rcp_ff);
         vec_in[i]    = quot_prod[i][RCP_SHIFT-COEF_FRAC_BITS +: VW];
      end
      vec_in[CHAN_ALPHA] = s1_alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         vec_ff <= vec_in;
      end
   end

endmodule

// ----- design/color_matrix_pixel_filter.sv -----
// ----------------------------------------------------------------------------
// color_matrix_pixel_filter
// colour matrix filter for premultiplied 8-bit argb pixels in fixed point
// ----------------------------------------------------------------------------
// Takes one premultiplied ARGB pixel per transaction and returns one filtered
// premultiplied pixel per transaction, in order. The pipeline holds eight
// register stages, and a new pixel can be taken every cycle while the output
// is not stalled, so the sustained rate is one pixel per cycle. Each stage is
// one step of work (reciprocal table lookup, reciprocal multiply, coefficient
// multiplies, four-term sum, offset and saturate, clamp, alpha multiply, byte
// scaling), and that step sets the clock period. Stalls collapse bubbles
// stage by stage; req_ready stays high while any stage ahead has room. Matrix
// rows and offsets are signed Q4.F words in 16-bit slots; write them only
// while the pipe is empty.
`timescale 1ns / 1ps

`include "color_matrix_pixel_filter_macros.svh"

module color_matrix_pixel_filter
   import cmpf_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [PIX_WIDTH-1:0] req_pixel_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_WIDTH-1:0] rsp_pixel_out,
   input  logic                 csr_write_enable,
   input  csr_index_type        csr_index,
   input  logic [CSR_WIDTH-1:0] csr_write_data
);

   // widths of the fixed-point path
   localparam int VW = CHAN_BITS + COEF_FRAC_BITS;      // unpremultiplied lane
   localparam int PW = VW + 1 + COEF_WIDTH;             // one product
   localparam int SW = PW + 2;                          // four-term sum
   localparam int TW = SW + 1;                          // sum plus offset
   localparam int IW = 9 + COEF_FRAC_BITS;              // intermediate lane
   localparam int CW = COEF_FRAC_BITS + 1;              // clamped 0..1
   localparam int MW = 2 * CW;                          // colour times alpha
   localparam int XW = MW + CHAN_BITS;                  // times 255
   localparam int AW = CW + CHAN_BITS;                  // alpha times 255
   localparam int STAGES = 6;

   localparam longint MID_MAX = (64'sd1 <<< (IW - 1)) - 64'sd1;
   localparam longint MID_MIN = -(64'sd1 <<< (IW - 1));
   localparam logic signed [IW-1:0] ZERO_MID = '0;
   localparam logic signed [IW-1:0] ONE_MID  = IW'(64'd1 << COEF_FRAC_BITS);
   localparam logic [CW-1:0]        ONE_CLAMP = CW'(64'd1 << COEF_FRAC_BITS);

   // configuration registers
   logic [CSR_WIDTH-1:0] matrix_row_zero_ff;
   logic [CSR_WIDTH-1:0] matrix_row_one_ff;
   logic [CSR_WIDTH-1:0] matrix_row_two_ff;
   logic [CSR_WIDTH-1:0] matrix_row_three_ff;
   logic [CSR_WIDTH-1:0] offset_vector_ff;
   logic [CSR_WIDTH-1:0] rows [CHAN_COUNT];

   // handshake chain: a stage loads when it is empty or the next one moves
   logic [STAGES-1:0] stg_valid_ff;
   logic [STAGES:0]   stg_ready;

   // unpremultiply front end
   logic                          unp_valid;
   logic [CHAN_COUNT-1:0][VW-1:0] unp_vec;

   // stage 0: products, stage 1: sums, stage 2: offset and saturate
   logic signed [PW-1:0] prod_in [CHAN_COUNT][CHAN_COUNT];
   logic signed [PW-1:0] prod_ff [CHAN_COUNT][CHAN_COUNT];
   logic signed [SW-1:0] sum_in  [CHAN_COUNT];
   logic signed [SW-1:0] sum_ff  [CHAN_COUNT];
   logic signed [SW-1:0] sum_shift [CHAN_COUNT];
   logic signed [TW-1:0] total   [CHAN_COUNT];
   logic signed [IW-1:0] res_in  [CHAN_COUNT];
   logic signed [IW-1:0] res_ff  [CHAN_COUNT];

   // stage 3: clamp, stage 4: alpha multiply, stage 5: output byte
   logic [CW-1:0]        clamp_in [CHAN_COUNT];
   logic                 st3_zero_ff;
   logic [CW-1:0]        st3_alpha_ff;
   logic [CW-1:0]        st3_col_ff [COLOR_COUNT];
   logic [AW-1:0]        alpha_scaled;
   logic                 st4_zero_ff;
   logic [CHAN_BITS-1:0] st4_abyte_ff;
   logic [MW-1:0]        st4_cprod_ff [COLOR_COUNT];
   logic [XW-1:0]        col_scaled [COLOR_COUNT];
   logic [PIX_WIDTH-1:0] rsp_pixel_out_in;
   logic [PIX_WIDTH-1:0] rsp_pixel_out_ff;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_row_zero_ff  <= ROW_ZERO_RESET;
         matrix_row_one_ff   <= ROW_ONE_RESET;
         matrix_row_two_ff   <= ROW_TWO_RESET;
         matrix_row_three_ff <= ROW_THREE_RESET;
         offset_vector_ff    <= OFFSET_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROW_ZERO:  matrix_row_zero_ff  <= csr_write_data;
            CSR_ROW_ONE:   matrix_row_one_ff   <= csr_write_data;
            CSR_ROW_TWO:   matrix_row_two_ff   <= csr_write_data;
            CSR_ROW_THREE: matrix_row_three_ff <= csr_write_data;
            CSR_OFFSET:    offset_vector_ff    <= csr_write_data;
            default: begin
               // writes past the last register are dropped
            end
         endcase
      end
   end

   assign rows[0] = matrix_row_zero_ff;
   assign rows[1] = matrix_row_one_ff;
   assign rows[2] = matrix_row_two_ff;
   assign rows[3] = matrix_row_three_ff;

   // ---------------------------------------------------------------- front end
   // a zero alpha byte reads zero from both tables, so the whole vector is
   // zero and the matrix product below is zero without a separate path
   cmpf_unpremul #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_unpremul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pixel  (req_pixel_in),
      .out_valid (unp_valid),
      .out_ready (stg_ready[0]),
      .out_vec   (unp_vec)
   );

   // ---------------------------------------------------------------- handshake
   always_comb begin
      stg_ready[STAGES] = rsp_ready;
      for (int k = 0; k < STAGES; k++) begin
         stg_ready[k] = !stg_valid_ff[k] || stg_ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         if (stg_ready[0]) begin
            stg_valid_ff[0] <= unp_valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (stg_ready[k]) begin
               stg_valid_ff[k] <= stg_valid_ff[k-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------- stage 0
   // input lane i times coefficient (row i, slot j) feeds output lane j
   always_comb begin
      for (int i = 0; i < CHAN_COUNT; i++) begin
         for (int j = 0; j < CHAN_COUNT; j++) begin
            prod_in[i][j] = PW'($signed({1'b0, unp_vec[i]}))
                          * PW'($signed(rows[i][COEF_WIDTH*j +: COEF_WIDTH]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[0]) begin
         prod_ff <= prod_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      for (int j = 0; j < CHAN_COUNT; j++) begin
         sum_in[j] = (SW'(prod_ff[0][j]) + SW'(prod_ff[1][j]))
                   + (SW'(prod_ff[2][j]) + SW'(prod_ff[3][j]));
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[1]) begin
         sum_ff <= sum_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // arithmetic shift rounds toward minus infinity, then offset and saturate
   always_comb begin
      for (int j = 0; j < CHAN_COUNT; j++) begin
         sum_shift[j] = sum_ff[j] >>> COEF_FRAC_BITS;
         total[j] = TW'(sum_shift[j])
                  + TW'($signed(offset_vector_ff[COEF_WIDTH*j +: COEF_WIDTH]));
         priority if (total[j] > TW'(MID_MAX)) begin
            res_in[j] = IW'(MID_MAX);
         end else if (total[j] < TW'(MID_MIN)) begin
            res_in[j] = IW'(MID_MIN);
         end else begin
            res_in[j] = IW'(total[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[2]) begin
         res_ff <= res_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // every lane clamped to 0..1; a non-positive alpha kills the pixel
   always_comb begin
      for (int j = 0; j < CHAN_COUNT; j++) begin
         priority if (res_ff[j] < ZERO_MID) begin
            clamp_in[j] = '0;
         end else if (res_ff[j] > ONE_MID) begin
            clamp_in[j] = ONE_CLAMP;
         end else begin
            clamp_in[j] = res_ff[j][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[3]) begin
         st3_zero_ff  <= (res_ff[CHAN_ALPHA] <= ZERO_MID);
         st3_alpha_ff <= clamp_in[CHAN_ALPHA];
         for (int j = 0; j < COLOR_COUNT; j++) begin
            st3_col_ff[j] <= clamp_in[j];
         end
      end
   end

   // ---------------------------------------------------------------- stage 4
   assign alpha_scaled = AW'(st3_alpha_ff) * AW'(PIX_MAX);

   always_ff @(posedge clock) begin
      if (stg_ready[4]) begin
         st4_zero_ff  <= st3_zero_ff;
         st4_abyte_ff <= alpha_scaled[COEF_FRAC_BITS +: CHAN_BITS];
         for (int j = 0; j < COLOR_COUNT; j++) begin
            st4_cprod_ff[j] <= MW'(st3_col_ff[j]) * MW'(st3_alpha_ff);
         end
      end
   end

   // ---------------------------------------------------------------- stage 5
   // premultiplied colour byte is c * alpha * 255 over 2^(2f)
   always_comb begin
      for (int j = 0; j < COLOR_COUNT; j++) begin
         col_scaled[j] = XW'(st4_cprod_ff[j]) * XW'(PIX_MAX);
      end
      if (st4_zero_ff) begin
         rsp_pixel_out_in = '0;
      end else begin
         rsp_pixel_out_in = {st4_abyte_ff,
                             col_scaled[0][2*COEF_FRAC_BITS +: CHAN_BITS],
                             col_scaled[1][2*COEF_FRAC_BITS +: CHAN_BITS],
                             col_scaled[2][2*COEF_FRAC_BITS +: CHAN_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (stg_ready[5]) begin
         rsp_pixel_out_ff <= rsp_pixel_out_in;
      end
   end

   assign rsp_valid     = stg_valid_ff[STAGES-1];
   assign rsp_pixel_out = rsp_pixel_out_ff;

   // ---------------------------------------------------------------- checks
   // a zero alpha byte leaves nothing in the colour bytes
   `CMPF_ASSERT(a_zero_alpha_clear,
      rsp_valid && (rsp_pixel_out[31:24] == 8'd0),
      rsp_pixel_out == 32'd0,
      "alpha byte zero with colour left")
   // premultiplied output: no colour byte above the alpha byte
   `CMPF_ASSERT(a_premul_bound,
      rsp_valid,
      (rsp_pixel_out[23:16] <= rsp_pixel_out[31:24])
         && (rsp_pixel_out[15:8] <= rsp_pixel_out[31:24])
         && (rsp_pixel_out[7:0] <= rsp_pixel_out[31:24]),
      "colour byte above alpha byte")
   // a stalled stage keeps its transaction
   `CMPF_ASSERT_NEXT(a_stage_hold,
      stg_valid_ff[3] && !stg_ready[4],
      stg_valid_ff[3],
      "stalled stage lost its transaction")

endmodule
